FILE: rtl/core/scpe_pkg.sv
// Shared constants, types and tables for the sampled ellipse closest-point block.
package scpe_pkg;

    parameter int NUM_SAMPLES_DEF = 1000;
    parameter int COORD_BITS_DEF  = 16;

    localparam int PHASE_W      = 32;
    localparam int ANG_W        = 30;
    localparam int HALF_PI_W    = 31;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_W       = 17;
    localparam int FRAC_BITS    = 15;
    localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

    localparam logic [HALF_PI_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
        34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
        34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
        34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
        34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
        34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
    };

    typedef struct packed {
        logic first;
        logic last;
    } tag_t;

endpackage

FILE: rtl/core/scpe_if.sv
// Valid/ready channel interfaces for query words and result words.
interface scpe_in_if #(
    parameter int COORD_BITS = scpe_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [COORD_BITS-2:0] semi_axis_x;
    logic        [COORD_BITS-2:0] semi_axis_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;

    modport source (
        output valid, center_x, center_y, semi_axis_x, semi_axis_y, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, semi_axis_x, semi_axis_y, query_x, query_y,
        output ready
    );
endinterface

interface scpe_out_if #(
    parameter int COORD_BITS = scpe_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic signed [COORD_BITS-1:0] nearest_y;

    modport source (
        output valid, nearest_x, nearest_y,
        input  ready
    );
    modport sink (
        input  valid, nearest_x, nearest_y,
        output ready
    );
endinterface

FILE: rtl/core/scpe_trig.sv
// Pipelined CORDIC: phase in, Q1.15 cosine and sine out, one step per stage.
module scpe_trig (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  scpe_pkg::tag_t                    in_tag,
    input  logic [scpe_pkg::PHASE_W-1:0]      phase,
    output logic                              out_vld,
    output scpe_pkg::tag_t                    out_tag,
    output logic signed [scpe_pkg::TRIG_W-1:0] cos_q,
    output logic signed [scpe_pkg::TRIG_W-1:0] sin_q
);
    import scpe_pkg::*;

    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] sum;
        logic signed [CORDIC_W:0] sh;
        logic signed [CORDIC_W:0] qmax;
        logic signed [CORDIC_W:0] qmin;
        sum  = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(ROUND_HALF);
        sh   = sum >>> FRAC_BITS;
        qmax = (CORDIC_W+1)'(32767);
        qmin = -qmax - (CORDIC_W+1)'(1);
        if (sh > qmax)
        begin
            return TRIG_W'(qmax);
        end
        else if (sh < qmin)
        begin
            return TRIG_W'(qmin);
        end
        return TRIG_W'(sh);
    endfunction

    logic                       vld_reg  [CORDIC_STEPS+1];
    tag_t                       tag_reg  [CORDIC_STEPS+1];
    logic [1:0]                 quad_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] x_reg    [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg    [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg    [CORDIC_STEPS+1];

    logic [ANG_W+HALF_PI_W-1:0] ang_prod;
    logic signed [CORDIC_W-1:0] z_next;

    assign ang_prod = (ANG_W+HALF_PI_W)'(phase[ANG_W-1:0]) * (ANG_W+HALF_PI_W)'(HALF_PI_Q30);
    assign z_next   = $signed(CORDIC_W'(ang_prod[ANG_W+HALF_PI_W-1:ANG_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0]  <= in_tag;
            quad_reg[0] <= phase[PHASE_W-1:PHASE_W-2];
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k+1]  <= tag_reg[k];
                quad_reg[k+1] <= quad_reg[k];
                if (!z_reg[k][CORDIC_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - ATAN_Q30[k];
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + ATAN_Q30[k];
                end
            end
        end
    end

    logic signed [TRIG_W-1:0] xq;
    logic signed [TRIG_W-1:0] yq;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;
    logic                     out_vld_reg;
    tag_t                     out_tag_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    assign xq = to_q15(x_reg[CORDIC_STEPS]);
    assign yq = to_q15(y_reg[CORDIC_STEPS]);

    always_comb
    begin
        unique case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                cos_next = xq;
                sin_next = yq;
            end
            2'd1:
            begin
                cos_next = -yq;
                sin_next = xq;
            end
            2'd2:
            begin
                cos_next = -xq;
                sin_next = -yq;
            end
            default:
            begin
                cos_next = yq;
                sin_next = -xq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tag_reg <= tag_reg[CORDIC_STEPS];
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_tag = out_tag_reg;
    assign cos_q   = cos_reg;
    assign sin_q   = sin_reg;

endmodule

FILE: rtl/core/sampled_closest_point_on_ellipse_top.sv
// Top level: nearest of NUM_SAMPLES+1 sampled ellipse points to a query point.
//
//  channel  dir  word                                                  handshake
//  in_ch    in   center_x/y, semi_axis_x/y, query_x/y                  valid/ready
//  out_ch   out  nearest_x, nearest_y                                  valid/ready
//
// One query word at a time; a sample enters the pipeline every cycle, and the result is
// registered once the last sample has passed the CORDIC stages and the scale, round,
// distance and compare stages; in_ch.ready returns in the same cycle as out_ch.valid.
// rst_n clears all valid bits and control; no clearing pass.
// A held result stalls the whole pipeline only when the last sample would retire.
module sampled_closest_point_on_ellipse_top #(
    parameter int NUM_SAMPLES = scpe_pkg::NUM_SAMPLES_DEF,
    parameter int COORD_BITS  = scpe_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    scpe_in_if.sink    in_ch,
    scpe_out_if.source out_ch
);
    import scpe_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int CNT_W   = $clog2(NUM_SAMPLES + 1);
    localparam int REM_W   = $clog2(NUM_SAMPLES) + 1;
    localparam int PROD_W  = COORD_BITS + TRIG_W;
    localparam int POS_W   = PROD_W + 2;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam logic [PHASE_W-1:0] PHASE_Q = PHASE_W'((64'd1 << PHASE_W) / NUM_SAMPLES);
    localparam logic [REM_W-1:0]   PHASE_R = REM_W'((64'd1 << PHASE_W) % NUM_SAMPLES);
    localparam logic [REM_W-1:0]   REM_MOD = REM_W'(NUM_SAMPLES);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(NUM_SAMPLES);
    localparam logic signed [POS_W-1:0] CMAX = POS_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [POS_W-1:0] CMIN = -CMAX - POS_W'(1);

    // word registers, stable while busy
    logic signed [CB-1:0] cx_reg;
    logic signed [CB-1:0] cy_reg;
    logic        [CB-2:0] ax_reg;
    logic        [CB-2:0] ay_reg;
    logic signed [CB-1:0] qx_reg;
    logic signed [CB-1:0] qy_reg;

    logic busy_reg;
    logic issue_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [REM_W-1:0]   rem_reg;

    logic in_acc;
    logic en;
    logic stall;
    logic retire;
    tag_t issue_tag;

    // sample pipeline
    logic                     trig_vld;
    tag_t                     trig_tag;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;

    logic                     p1_vld_reg;
    tag_t                     p1_tag_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;

    logic                 p2_vld_reg;
    tag_t                 p2_tag_reg;
    logic signed [CB-1:0] ex2_reg;
    logic signed [CB-1:0] ey2_reg;

    logic                 p3_vld_reg;
    tag_t                 p3_tag_reg;
    logic signed [CB-1:0] ex3_reg;
    logic signed [CB-1:0] ey3_reg;
    logic        [CB-1:0] mx_reg;
    logic        [CB-1:0] my_reg;

    logic                   p4_vld_reg;
    tag_t                   p4_tag_reg;
    logic signed [CB-1:0]   ex4_reg;
    logic signed [CB-1:0]   ey4_reg;
    logic [2*CB-1:0]        sqx_reg;
    logic [2*CB-1:0]        sqy_reg;

    logic                 p5_vld_reg;
    tag_t                 p5_tag_reg;
    logic signed [CB-1:0] ex5_reg;
    logic signed [CB-1:0] ey5_reg;
    logic [DIST_W-1:0]    dist_reg;

    logic [DIST_W-1:0]    best_dist_reg;
    logic signed [CB-1:0] bx_reg;
    logic signed [CB-1:0] by_reg;

    logic                 out_vld_reg;
    logic signed [CB-1:0] out_x_reg;
    logic signed [CB-1:0] out_y_reg;

    // issue
    logic [REM_W-1:0]   rem_sum;
    logic               rem_wrap;
    logic [REM_W-1:0]   rem_next;
    logic [PHASE_W-1:0] phase_next;

    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !busy_reg;

    assign stall  = p5_vld_reg && p5_tag_reg.last && out_vld_reg && !out_ch.ready;
    assign en     = !stall;
    assign retire = en && p5_vld_reg && p5_tag_reg.last;

    assign rem_sum    = rem_reg + PHASE_R;
    assign rem_wrap   = rem_sum >= REM_MOD;
    assign rem_next   = rem_wrap ? rem_sum - REM_MOD : rem_sum;
    assign phase_next = phase_reg + PHASE_Q + PHASE_W'(rem_wrap);

    assign issue_tag.first = cnt_reg == '0;
    assign issue_tag.last  = cnt_reg == CNT_LAST;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cx_reg <= in_ch.center_x;
            cy_reg <= in_ch.center_y;
            ax_reg <= in_ch.semi_axis_x;
            ay_reg <= in_ch.semi_axis_y;
            qx_reg <= in_ch.query_x;
            qy_reg <= in_ch.query_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (retire)
            begin
                busy_reg <= 1'b0;
            end

            if (in_acc)
            begin
                issue_reg <= 1'b1;
                cnt_reg   <= '0;
                phase_reg <= '0;
                rem_reg   <= '0;
            end
            else if (en && issue_reg)
            begin
                issue_reg <= !issue_tag.last;
                cnt_reg   <= cnt_reg + CNT_W'(1);
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
            end
        end
    end

    scpe_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (issue_reg),
        .in_tag  (issue_tag),
        .phase   (phase_reg),
        .out_vld (trig_vld),
        .out_tag (trig_tag),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    // scale by semi-axes
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;

    assign px_next = PROD_W'($signed({1'b0, ax_reg})) * PROD_W'(cos_q);
    assign py_next = PROD_W'($signed({1'b0, ay_reg})) * PROD_W'(sin_q);

    // round, add center, saturate
    logic signed [PROD_W:0]  rx;
    logic signed [PROD_W:0]  ry;
    logic signed [POS_W-1:0] posx;
    logic signed [POS_W-1:0] posy;
    logic signed [CB-1:0]    ex_next;
    logic signed [CB-1:0]    ey_next;

    assign rx   = ((PROD_W+1)'(px_reg) + (PROD_W+1)'(ROUND_HALF)) >>> FRAC_BITS;
    assign ry   = ((PROD_W+1)'(py_reg) + (PROD_W+1)'(ROUND_HALF)) >>> FRAC_BITS;
    assign posx = POS_W'(cx_reg) + POS_W'(rx);
    assign posy = POS_W'(cy_reg) + POS_W'(ry);

    always_comb
    begin
        priority if (posx > CMAX)
        begin
            ex_next = CB'(CMAX);
        end
        else if (posx < CMIN)
        begin
            ex_next = CB'(CMIN);
        end
        else
        begin
            ex_next = CB'(posx);
        end
        priority if (posy > CMAX)
        begin
            ey_next = CB'(CMAX);
        end
        else if (posy < CMIN)
        begin
            ey_next = CB'(CMIN);
        end
        else
        begin
            ey_next = CB'(posy);
        end
    end

    // distance magnitudes
    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    logic signed [CB:0] adx;
    logic signed [CB:0] ady;

    assign dx  = (CB+1)'(qx_reg) - (CB+1)'(ex2_reg);
    assign dy  = (CB+1)'(qy_reg) - (CB+1)'(ey2_reg);
    assign adx = dx[CB] ? -dx : dx;
    assign ady = dy[CB] ? -dy : dy;

    // compare; earliest sample wins ties
    logic                 take;
    logic signed [CB-1:0] sel_x;
    logic signed [CB-1:0] sel_y;

    assign take  = p5_tag_reg.first || (dist_reg < best_dist_reg);
    assign sel_x = take ? ex5_reg : bx_reg;
    assign sel_y = take ? ey5_reg : by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= trig_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_tag_reg <= trig_tag;
            px_reg     <= px_next;
            py_reg     <= py_next;

            p2_tag_reg <= p1_tag_reg;
            ex2_reg    <= ex_next;
            ey2_reg    <= ey_next;

            p3_tag_reg <= p2_tag_reg;
            ex3_reg    <= ex2_reg;
            ey3_reg    <= ey2_reg;
            mx_reg     <= CB'(adx);
            my_reg     <= CB'(ady);

            p4_tag_reg <= p3_tag_reg;
            ex4_reg    <= ex3_reg;
            ey4_reg    <= ey3_reg;
            sqx_reg    <= (2*CB)'(mx_reg) * (2*CB)'(mx_reg);
            sqy_reg    <= (2*CB)'(my_reg) * (2*CB)'(my_reg);

            p5_tag_reg <= p4_tag_reg;
            ex5_reg    <= ex4_reg;
            ey5_reg    <= ey4_reg;
            dist_reg   <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

            if (p5_vld_reg && take)
            begin
                best_dist_reg <= dist_reg;
                bx_reg        <= ex5_reg;
                by_reg        <= ey5_reg;
            end
        end

        if (retire)
        begin
            out_x_reg <= sel_x;
            out_y_reg <= sel_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (retire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.nearest_x = out_x_reg;
    assign out_ch.nearest_y = out_y_reg;

    a_issue_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> busy_reg)
        else $error("sample issue outside a busy word");

    a_acc_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> busy_reg && issue_reg && cnt_reg == '0)
        else $error("accepted word did not start issue");

    a_retire_out: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> out_vld_reg && !busy_reg)
        else $error("last sample retired without a result");

    a_first_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !issue_reg && !p5_vld_reg && !trig_vld)
        else $error("pipeline busy while accepting");

endmodule

FILE: sim/tb.sv
// Testbench for the sampled ellipse closest-point block: directed, stall and random query words.
module tb;

    import scpe_pkg::*;

    localparam int NS           = NUM_SAMPLES_DEF;
    localparam int CB           = COORD_BITS_DEF;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = NS + 100;

    localparam longint ATAN_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

    typedef struct packed {
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic        [CB-2:0] ax;
        logic        [CB-2:0] ay;
        logic signed [CB-1:0] qx;
        logic signed [CB-1:0] qy;
    } query_t;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic steady   = 1'b0;
    logic hold_req = 1'b0;
    int   errors   = 0;

    longint cos_tab [0:NS];
    longint sin_tab [0:NS];
    point_t nearest_q [$];

    scpe_in_if  #(.COORD_BITS(CB)) in_ch ();
    scpe_out_if #(.COORD_BITS(CB)) out_ch ();

    sampled_closest_point_on_ellipse_top #(
        .NUM_SAMPLES(NS),
        .COORD_BITS (CB)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[CB-1:0];
    endfunction

    function automatic logic [CB-2:0] clamp_axis(longint v);
        if (v > 32767)
            return 15'h7FFF;
        if (v < 0)
            return 15'h0;
        return v[CB-2:0];
    endfunction

    function automatic point_t nearest_sample(query_t w);
        point_t best;
        longint ex;
        longint ey;
        longint dx;
        longint dy;
        longint unsigned sq_dist;
        longint unsigned best_dist;
        best      = '0;
        best_dist = '1;
        for (int i = 0; i <= NS; i++)
        begin
            ex = clamp_coord(longint'(w.cx) + ((longint'(w.ax) * cos_tab[i] + 16384) >>> 15));
            ey = clamp_coord(longint'(w.cy) + ((longint'(w.ay) * sin_tab[i] + 16384) >>> 15));
            dx = longint'(w.qx) - ex;
            dy = longint'(w.qy) - ey;
            sq_dist = longint'(dx * dx) + longint'(dy * dy);
            if (i == 0 || sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best.x    = ex[CB-1:0];
                best.y    = ey[CB-1:0];
            end
        end
        return best;
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_word(input longint cx, cy, ax, ay, qx, qy);
        query_t w;
        point_t want;
        int     gap;
        w.cx = clamp_coord(cx);
        w.cy = clamp_coord(cy);
        w.ax = clamp_axis(ax);
        w.ay = clamp_axis(ay);
        w.qx = clamp_coord(qx);
        w.qy = clamp_coord(qy);
        want = nearest_sample(w);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.center_x    <= w.cx;
        in_ch.center_y    <= w.cy;
        in_ch.semi_axis_x <= w.ax;
        in_ch.semi_axis_y <= w.ay;
        in_ch.query_x     <= w.qx;
        in_ch.query_y     <= w.qy;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        nearest_q.push_back(want);
        @(negedge clk);
    endtask

    function automatic longint rand_coord();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic send_random_word();
        longint cx;
        longint cy;
        longint ax;
        longint ay;
        longint qx;
        longint qy;
        int     j;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                cx = rand_coord();
                cy = rand_coord();
                ax = $urandom_range(0, 32767);
                ay = $urandom_range(0, 32767);
                qx = rand_coord();
                qy = rand_coord();
            end
            3, 4, 5:
            begin
                cx = longint'($urandom_range(0, 16000)) - 8000;
                cy = longint'($urandom_range(0, 16000)) - 8000;
                ax = $urandom_range(0, 2000);
                ay = $urandom_range(0, 2000);
                qx = cx + longint'($urandom_range(0, 6000)) - 3000;
                qy = cy + longint'($urandom_range(0, 6000)) - 3000;
            end
            6, 7:
            begin
                cx = longint'($urandom_range(0, 40000)) - 20000;
                cy = longint'($urandom_range(0, 40000)) - 20000;
                ax = $urandom_range(0, 12000);
                ay = $urandom_range(0, 12000);
                j  = $urandom_range(0, NS);
                qx = cx + ((ax * cos_tab[j] + 16384) >>> 15) + longint'($urandom_range(0, 8)) - 4;
                qy = cy + ((ay * sin_tab[j] + 16384) >>> 15) + longint'($urandom_range(0, 8)) - 4;
            end
            8:
            begin
                cx = rand_coord();
                cy = rand_coord();
                ax = $urandom_range(0, 32767);
                ay = ($urandom_range(0, 1) == 0) ? ax : longint'($urandom_range(0, 32767));
                qx = cx;
                qy = cy;
            end
            default:
            begin
                cx = ($urandom_range(0, 1) == 0) ? 32767 - longint'($urandom_range(0, 500))
                                                 : -32768 + longint'($urandom_range(0, 500));
                cy = ($urandom_range(0, 1) == 0) ? 32767 - longint'($urandom_range(0, 500))
                                                 : -32768 + longint'($urandom_range(0, 500));
                ax = 32767 - longint'($urandom_range(0, 4000));
                ay = 32767 - longint'($urandom_range(0, 4000));
                qx = rand_coord();
                qy = rand_coord();
            end
        endcase
        send_word(cx, cy, ax, ay, qx, qy);
    endtask

    task automatic test_extremes();
        send_word(0, 0, 0, 0, 0, 0);
        send_word(0, 0, 32767, 32767, 0, 0);
        send_word(0, 0, 32767, 32767, 32767, 32767);
        send_word(32767, 32767, 32767, 32767, -32768, -32768);
        send_word(-32768, -32768, 32767, 32767, 32767, 32767);
        send_word(32767, -32768, 32767, 32767, 32767, -32768);
        send_word(-32768, 32767, 32767, 32767, -32768, 32767);
        send_word(1234, -4321, 0, 0, -32768, 32767);
        send_word(0, 0, 32767, 0, 100, 5000);
        send_word(0, 0, 0, 32767, -5000, -100);
        send_word(0, 0, 4096, 2048, 4096, 0);
        send_word(0, 0, 4096, 2048, 0, 2048);
        send_word(0, 0, 4096, 2048, -4096, 0);
        send_word(0, 0, 4096, 2048, 0, -2048);
        send_word(100, 100, 16, 16, 120, 120);
        send_word(-1, -1, 1, 1, -1, -1);
        send_word(32767, 32767, 0, 0, 32767, 32767);
        send_word(-32768, -32768, 1, 32767, -32768, -32768);
    endtask

    // Output held off long enough for the block to back up into its input.
    task automatic test_output_stall();
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (4)
            send_random_word();
    endtask

    task automatic test_random_words();
        repeat (510)
            send_random_word();
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (60)
            send_random_word();
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin : sink_ctrl
        int burst;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 6);
                out_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        point_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (nearest_q.size() == 0)
            begin
                $display("%0t unexpected word: actual x %0d y %0d", $time,
                         out_ch.nearest_x, out_ch.nearest_y);
                errors++;
            end
            else
            begin
                want = nearest_q.pop_front();
                if (out_ch.nearest_x !== want.x)
                begin
                    $display("%0t nearest_x: expected %0d actual %0d", $time,
                             want.x, out_ch.nearest_x);
                    errors++;
                end
                if (out_ch.nearest_y !== want.y)
                begin
                    $display("%0t nearest_y: expected %0d actual %0d", $time,
                             want.y, out_ch.nearest_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : main
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint unsigned num;
        longint unsigned ru;
        logic [31:0] phase;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.center_x    = '0;
        in_ch.center_y    = '0;
        in_ch.semi_axis_x = '0;
        in_ch.semi_axis_y = '0;
        in_ch.query_x     = '0;
        in_ch.query_y     = '0;

        // cos/sin per sample, Q1.15
        for (int i = 0; i <= NS; i++)
        begin
            num   = longint'(i);
            num   = (num << 32) / NS;
            phase = num[31:0];
            ru    = {34'd0, phase[29:0]};
            z     = longint'((ru * 64'd1686629713) >> 30);
            x     = 652032874;
            y     = 0;
            for (int k = 0; k < 24; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= ATAN_TAB[k];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += ATAN_TAB[k];
                end
            end
            x = (x + 16384) >>> 15;
            y = (y + 16384) >>> 15;
            x = (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
            y = (y > 32767) ? 32767 : ((y < -32768) ? -32768 : y);
            case (quadrant_t'(phase[31:30]))
                QUAD_0:
                begin
                    cos_tab[i] = x;
                    sin_tab[i] = y;
                end
                QUAD_1:
                begin
                    cos_tab[i] = -y;
                    sin_tab[i] = x;
                end
                QUAD_2:
                begin
                    cos_tab[i] = -x;
                    sin_tab[i] = -y;
                end
                default:
                begin
                    cos_tab[i] = y;
                    sin_tab[i] = -x;
                end
            endcase
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_output_stall();
        test_random_words();
        test_back_to_back();

        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && nearest_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
